/* rtl/core/mck_pkg.sv */
// Shared types, constants and lookup functions for the Morse keyer.
// Used by mck_front, mck_queue, mck_back and morse_code_keyer_unit.
`timescale 1ns / 1ps

package mck_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int WPM_W   = 6;
    localparam int FREQ_W  = 13;
    localparam int UNITS_W = 4;
    localparam int DUR_W   = 11;
    localparam int MS_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Code shape
    localparam int MAX_ELEMS = 6;
    localparam int LEN_W     = 3;
    localparam int IDX_W     = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WPM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE = 1'd1;

    // Reset values
    localparam logic [WPM_W-1:0]  WPM_RESET  = 6'd20;
    localparam logic [FREQ_W-1:0] TONE_RESET = 13'd700;
    localparam logic [WPM_W-1:0]  MAX_WPM    = 6'd40;

    // Segment lengths in units
    localparam logic [UNITS_W-1:0] DOT_UNITS      = 4'd1;
    localparam logic [UNITS_W-1:0] DASH_UNITS     = 4'd3;
    localparam logic [UNITS_W-1:0] GAP_UNITS      = 4'd2;
    localparam logic [UNITS_W-1:0] END_GAP_UNITS  = 4'd5;
    localparam logic [UNITS_W-1:0] WORD_GAP_UNITS = 4'd11;

    // One classified character; pattern bit i is element i, 1 for a dash
    typedef struct packed {
        logic                 coded;
        logic                 is_space;
        logic [LEN_W-1:0]     len;
        logic [MAX_ELEMS-1:0] pattern;
    } code_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // Map an ASCII character to its element pattern
    function automatic code_entry_t char_code(input logic [CHAR_W-1:0] c);
        code_entry_t           e;
        logic [CHAR_W-1:0]     u;
        e = '0;
        u = c;
        // Fold lowercase onto uppercase
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            u = c - 8'd32;
        end
        e.coded = 1'b1;
        unique case (u)
            8'h20: e.is_space = 1'b1;
            8'h41: {e.len, e.pattern} = {3'd2, 6'b000010}; // A
            8'h42: {e.len, e.pattern} = {3'd4, 6'b000001}; // B
            8'h43: {e.len, e.pattern} = {3'd4, 6'b000101}; // C
            8'h44: {e.len, e.pattern} = {3'd3, 6'b000001}; // D
            8'h45: {e.len, e.pattern} = {3'd1, 6'b000000}; // E
            8'h46: {e.len, e.pattern} = {3'd4, 6'b000100}; // F
            8'h47: {e.len, e.pattern} = {3'd3, 6'b000011}; // G
            8'h48: {e.len, e.pattern} = {3'd4, 6'b000000}; // H
            8'h49: {e.len, e.pattern} = {3'd2, 6'b000000}; // I
            8'h4A: {e.len, e.pattern} = {3'd4, 6'b001110}; // J
            8'h4B: {e.len, e.pattern} = {3'd3, 6'b000101}; // K
            8'h4C: {e.len, e.pattern} = {3'd4, 6'b000010}; // L
            8'h4D: {e.len, e.pattern} = {3'd2, 6'b000011}; // M
            8'h4E: {e.len, e.pattern} = {3'd2, 6'b000001}; // N
            8'h4F: {e.len, e.pattern} = {3'd3, 6'b000111}; // O
            8'h50: {e.len, e.pattern} = {3'd4, 6'b000110}; // P
            8'h51: {e.len, e.pattern} = {3'd4, 6'b001011}; // Q
            8'h52: {e.len, e.pattern} = {3'd3, 6'b000010}; // R
            8'h53: {e.len, e.pattern} = {3'd3, 6'b000000}; // S
            8'h54: {e.len, e.pattern} = {3'd1, 6'b000001}; // T
            8'h55: {e.len, e.pattern} = {3'd3, 6'b000100}; // U
            8'h56: {e.len, e.pattern} = {3'd4, 6'b001000}; // V
            8'h57: {e.len, e.pattern} = {3'd3, 6'b000110}; // W
            8'h58: {e.len, e.pattern} = {3'd4, 6'b001001}; // X
            8'h59: {e.len, e.pattern} = {3'd4, 6'b001101}; // Y
            8'h5A: {e.len, e.pattern} = {3'd4, 6'b000011}; // Z
            8'h30: {e.len, e.pattern} = {3'd5, 6'b011111}; // 0
            8'h31: {e.len, e.pattern} = {3'd5, 6'b011110}; // 1
            8'h32: {e.len, e.pattern} = {3'd5, 6'b011100}; // 2
            8'h33: {e.len, e.pattern} = {3'd5, 6'b011000}; // 3
            8'h34: {e.len, e.pattern} = {3'd5, 6'b010000}; // 4
            8'h35: {e.len, e.pattern} = {3'd5, 6'b000000}; // 5
            8'h36: {e.len, e.pattern} = {3'd5, 6'b000001}; // 6
            8'h37: {e.len, e.pattern} = {3'd5, 6'b000011}; // 7
            8'h38: {e.len, e.pattern} = {3'd5, 6'b000111}; // 8
            8'h39: {e.len, e.pattern} = {3'd5, 6'b001111}; // 9
            8'h3F: {e.len, e.pattern} = {3'd6, 6'b001100}; // ?
            8'h2E: {e.len, e.pattern} = {3'd6, 6'b101010}; // .
            8'h2C: {e.len, e.pattern} = {3'd6, 6'b110011}; // ,
            8'h2F: {e.len, e.pattern} = {3'd5, 6'b001001}; // /
            default: e.coded = 1'b0;
        endcase
        return e;
    endfunction

    // Unit length in ms for a keying speed, saturated at the top speed
    function automatic logic [MS_W-1:0] unit_ms(input logic [WPM_W-1:0] wpm);
        logic [WPM_W-1:0] s;
        logic [MS_W-1:0]  ms;
        s = (wpm > MAX_WPM) ? MAX_WPM : wpm;
        unique case (s)
            6'd10:   ms = 7'd120;
            6'd12:   ms = 7'd100;
            6'd15:   ms = 7'd80;
            6'd16:   ms = 7'd75;
            6'd18:   ms = 7'd67;
            6'd20:   ms = 7'd60;
            6'd22:   ms = 7'd55;
            6'd24:   ms = 7'd50;
            6'd25:   ms = 7'd48;
            6'd27:   ms = 7'd44;
            6'd30:   ms = 7'd40;
            6'd32:   ms = 7'd38;
            6'd35:   ms = 7'd34;
            6'd37:   ms = 7'd32;
            6'd40:   ms = 7'd30;
            default: ms = 7'd0;
        endcase
        return ms;
    endfunction

endpackage

/* rtl/core/mck_front.sv */
// Front end: accepts characters and classifies them into element patterns.
// Depends on mck_pkg; feeds mck_queue.
`timescale 1ns / 1ps

module mck_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mck_pkg::CHAR_W-1:0]  character,
    input  mck_pkg::queue_status_t      q_status,
    output logic                        push,
    output mck_pkg::code_entry_t        push_entry
);

    // Classify the incoming character
    assign push_entry = mck_pkg::char_code(character);

    // Take a transaction whenever the queue has room; drop uncoded characters
    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full && push_entry.coded;

endmodule

/* rtl/core/mck_queue.sv */
// Short FIFO of classified characters between front and back.
// Depends on mck_pkg.
`timescale 1ns / 1ps

module mck_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mck_pkg::code_entry_t    push_entry,
    input  logic                    pop,
    output mck_pkg::code_entry_t    pop_entry,
    output mck_pkg::queue_status_t  q_status
);

    mck_pkg::code_entry_t              mem [mck_pkg::QUEUE_DEPTH];
    logic [mck_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mck_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [mck_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [mck_pkg::QCNT_W-1:0] DEPTH_CNT =
        mck_pkg::QCNT_W'(mck_pkg::QUEUE_DEPTH);
    localparam logic [mck_pkg::QPTR_W-1:0] LAST_PTR =
        mck_pkg::QPTR_W'(mck_pkg::QUEUE_DEPTH - 1);

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == DEPTH_CNT);
    assign pop_entry      = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/mck_back.sv */
// Back end: walks one classified character and emits its key segments.
// Depends on mck_pkg; pops from mck_queue.
`timescale 1ns / 1ps

module mck_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mck_pkg::WPM_W-1:0]     wpm,
    input  logic [mck_pkg::FREQ_W-1:0]    tone_freq,
    input  mck_pkg::queue_status_t        q_status,
    input  mck_pkg::code_entry_t          pop_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          tone_on,
    output logic [mck_pkg::FREQ_W-1:0]    frequency_out,
    output logic [mck_pkg::UNITS_W-1:0]   unit_count,
    output logic [mck_pkg::DUR_W-1:0]     duration_ms,
    output logic                          last_segment
);

    logic                               busy_reg, busy_next;
    logic                               phase_reg, phase_next;  // 0 tone, 1 gap
    logic [mck_pkg::IDX_W-1:0]          idx_reg, idx_next;
    mck_pkg::code_entry_t               entry_reg, entry_next;

    logic                               out_valid_reg, out_valid_next;
    logic                               tone_on_reg, tone_on_next;
    logic [mck_pkg::FREQ_W-1:0]         freq_reg, freq_next;
    logic [mck_pkg::UNITS_W-1:0]        units_reg, units_next;
    logic [mck_pkg::DUR_W-1:0]          dur_reg, dur_next;
    logic                               last_reg, last_next;

    logic                               out_free;
    logic                               emit;
    logic                               seg_on;
    logic                               seg_last;
    logic [mck_pkg::UNITS_W-1:0]        seg_units;
    logic [mck_pkg::MS_W-1:0]           ms;
    logic                               elem_dash;
    logic                               elem_last;

    assign ms        = mck_pkg::unit_ms(wpm);
    assign out_free  = !out_valid_reg || out_ready;
    assign elem_dash = entry_reg.pattern[idx_reg];
    assign elem_last = (idx_reg == (entry_reg.len - 3'd1));

    // Sequence elements and gaps of the current character
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        entry_next = entry_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        seg_on     = 1'b0;
        seg_last   = 1'b0;
        seg_units  = mck_pkg::DOT_UNITS;
        if (!busy_reg)
        begin
            if (!q_status.empty)
            begin
                pop        = 1'b1;
                entry_next = pop_entry;
                busy_next  = 1'b1;
                idx_next   = '0;
                phase_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            emit = 1'b1;
            if (entry_reg.is_space)
            begin
                seg_units = mck_pkg::WORD_GAP_UNITS;
                seg_last  = 1'b1;
                busy_next = 1'b0;
            end
            else if (!phase_reg)
            begin
                seg_on     = 1'b1;
                seg_units  = elem_dash ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS;
                phase_next = 1'b1;
            end
            else
            begin
                seg_units = elem_last ? mck_pkg::END_GAP_UNITS : mck_pkg::GAP_UNITS;
                seg_last  = elem_last;
                if (elem_last)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    phase_next = 1'b0;
                end
            end
        end
    end

    // Load the output register, or drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        tone_on_next   = tone_on_reg;
        freq_next      = freq_reg;
        units_next     = units_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            tone_on_next   = seg_on;
            freq_next      = seg_on ? tone_freq : '0;
            units_next     = seg_units;
            dur_next       = {7'd0, seg_units} * {4'd0, ms};
            last_next      = seg_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        tone_on_reg <= tone_on_next;
        freq_reg    <= freq_next;
        units_reg   <= units_next;
        dur_reg     <= dur_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign tone_on       = tone_on_reg;
    assign frequency_out = freq_reg;
    assign unit_count    = units_reg;
    assign duration_ms   = dur_reg;
    assign last_segment  = last_reg;

endmodule

/* rtl/core/morse_code_keyer_unit.sv */
// Top level of the Morse keyer: config registers, front, queue and back.
// Depends on mck_pkg, mck_front, mck_queue and mck_back.
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------------
//  input     in_valid / in_ready   character
//  output    out_valid/out_ready   tone_on frequency_out unit_count duration_ms
//                                  last_segment
//  config    cfg_valid/cfg_ready   cfg_index cfg_data
//
// The front takes one character per cycle while the two-entry queue has room.
// The back pops a character, then emits its segments whenever the output is free:
// a tone and a gap per element, one word gap for a space; uncoded characters never reach it.
// A stalled output holds the back, which fills the queue and then drops in_ready.
// Reset clears control state and loads speed 20 and tone 700 Hz; cfg_ready is always high.
`timescale 1ns / 1ps

module morse_code_keyer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mck_pkg::CHAR_W-1:0]        character,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              tone_on,
    output logic [mck_pkg::FREQ_W-1:0]        frequency_out,
    output logic [mck_pkg::UNITS_W-1:0]       unit_count,
    output logic [mck_pkg::DUR_W-1:0]         duration_ms,
    output logic                              last_segment,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mck_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [mck_pkg::WPM_W-1:0]    wpm_reg, wpm_next;
    logic [mck_pkg::FREQ_W-1:0]   tone_reg, tone_next;

    mck_pkg::queue_status_t       q_status;
    mck_pkg::code_entry_t         push_entry;
    mck_pkg::code_entry_t         pop_entry;
    logic                         push;
    logic                         pop;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        wpm_next  = wpm_reg;
        tone_next = tone_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mck_pkg::CFG_WPM:  wpm_next  = cfg_data[mck_pkg::WPM_W-1:0];
                mck_pkg::CFG_TONE: tone_next = cfg_data[mck_pkg::FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpm_reg  <= mck_pkg::WPM_RESET;
            tone_reg <= mck_pkg::TONE_RESET;
        end
        else
        begin
            wpm_reg  <= wpm_next;
            tone_reg <= tone_next;
        end
    end

    mck_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    mck_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    mck_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wpm           (wpm_reg),
        .tone_freq     (tone_reg),
        .q_status      (q_status),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tone_on       (tone_on),
        .frequency_out (frequency_out),
        .unit_count    (unit_count),
        .duration_ms   (duration_ms),
        .last_segment  (last_segment)
    );

    // Silent segments carry no frequency
    a_silent_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tone_on |-> frequency_out == '0)
        else $error("silent segment carries a frequency");

    // The closing segment of a character is always silence
    a_last_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_segment |-> !tone_on)
        else $error("last segment has tone");

    // Tone segments are a dot or a dash
    a_tone_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tone_on |->
            unit_count == mck_pkg::DOT_UNITS || unit_count == mck_pkg::DASH_UNITS)
        else $error("tone segment has a bad length");

    // Never push into a full queue or pop from an empty one
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full) && !(pop && q_status.empty))
        else $error("queue overflow or underflow");

endmodule

/* tb/keyer_check.sv */
// Checker for the Morse keyer: tracks register writes, predicts key segments.
// Compares every output transaction with the oldest predicted segment.
// Depends on mck_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module keyer_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [mck_pkg::CHAR_W-1:0]     character,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           tone_on,
    input  logic [mck_pkg::FREQ_W-1:0]     frequency_out,
    input  logic [mck_pkg::UNITS_W-1:0]    unit_count,
    input  logic [mck_pkg::DUR_W-1:0]      duration_ms,
    input  logic                           last_segment,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mck_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);

    typedef struct {
        logic                        tone;
        logic [mck_pkg::FREQ_W-1:0]  freq;
        logic [mck_pkg::UNITS_W-1:0] units;
        logic [mck_pkg::DUR_W-1:0]   dur;
        logic                        last;
    } segment_t;

    // Unit length in ms per keying speed; gaps in the table give 0
    logic [mck_pkg::MS_W-1:0] ms_per_unit [0:40] = '{
        7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd120,
        7'd0, 7'd100, 7'd0, 7'd0, 7'd80, 7'd75, 7'd0, 7'd67, 7'd0, 7'd60,
        7'd0, 7'd55, 7'd0, 7'd50, 7'd48, 7'd0, 7'd44, 7'd0, 7'd0, 7'd40,
        7'd0, 7'd38, 7'd0, 7'd0, 7'd34, 7'd0, 7'd32, 7'd0, 7'd0, 7'd30
    };

    // Element strings: '1' is a dot, '3' is a dash
    string letter_codes [26] = '{
        "13", "3111", "3131", "311", "1", "1131", "331", "1111", "11",
        "1333", "313", "1311", "33", "31", "333", "1331", "3313", "131",
        "111", "3", "113", "1113", "133", "3113", "3133", "3311"
    };
    string digit_codes [10] = '{
        "33333", "13333", "11333", "11133", "11113",
        "11111", "31111", "33111", "33311", "33331"
    };

    logic [mck_pkg::WPM_W-1:0]  speed;
    logic [mck_pkg::FREQ_W-1:0] tone_hz;
    segment_t                   pending_segments [$];

    initial fail_count = 0;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ERROR %s: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    // Empty string means the character is not coded
    function automatic string elements_of(input logic [mck_pkg::CHAR_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return letter_codes[c - 8'h41];   // A..Z
        if (c >= 8'h61 && c <= 8'h7A) return letter_codes[c - 8'h61];   // a..z
        if (c >= 8'h30 && c <= 8'h39) return digit_codes[c - 8'h30];     // 0..9
        case (c)
            8'h3F:   return "113311";   // ?
            8'h2E:   return "131313";   // .
            8'h2C:   return "331133";   // ,
            8'h2F:   return "31131";    // /
            default: return "";
        endcase
    endfunction

    task automatic add_segment(input logic on, input logic [mck_pkg::UNITS_W-1:0] units,
                               input logic [mck_pkg::MS_W-1:0] ms, input logic last);
        segment_t seg;
        int       product;
        product   = units * ms;
        seg.tone  = on;
        seg.freq  = on ? tone_hz : '0;
        seg.units = units;
        seg.dur   = product[mck_pkg::DUR_W-1:0];
        seg.last  = last;
        pending_segments.push_back(seg);
    endtask

    // Predict the key segments of one character under the current registers
    task automatic key_character(input logic [mck_pkg::CHAR_W-1:0] c);
        logic [mck_pkg::WPM_W-1:0] s;
        logic [mck_pkg::MS_W-1:0]  ms;
        string                     code;
        s  = (speed > mck_pkg::MAX_WPM) ? mck_pkg::MAX_WPM : speed;
        ms = ms_per_unit[s];
        if (c == 8'h20)
        begin
            add_segment(1'b0, mck_pkg::WORD_GAP_UNITS, ms, 1'b1);
            return;
        end
        code = elements_of(c);
        for (int i = 0; i < code.len(); i++)
        begin
            add_segment(1'b1, (code[i] == "3") ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS,
                        ms, 1'b0);
            if (i == code.len() - 1)
                add_segment(1'b0, mck_pkg::END_GAP_UNITS, ms, 1'b1);
            else
                add_segment(1'b0, mck_pkg::GAP_UNITS, ms, 1'b0);
        end
    endtask

    // Compare output transactions, then track register writes and new characters
    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        if (!rst_n)
        begin
            speed   = mck_pkg::WPM_RESET;
            tone_hz = mck_pkg::TONE_RESET;
            pending_segments.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_segments.size() == 0)
                begin
                    report_mismatch("segment with none pending", int'(unit_count), 0);
                end
                else
                begin
                    want = pending_segments.pop_front();
                    if (tone_on !== want.tone)
                        report_mismatch("tone_on", int'(tone_on), int'(want.tone));
                    if (frequency_out !== want.freq)
                        report_mismatch("frequency_out", int'(frequency_out),
                                        int'(want.freq));
                    if (unit_count !== want.units)
                        report_mismatch("unit_count", int'(unit_count), int'(want.units));
                    if (duration_ms !== want.dur)
                        report_mismatch("duration_ms", int'(duration_ms), int'(want.dur));
                    if (last_segment !== want.last)
                        report_mismatch("last_segment", int'(last_segment),
                                        int'(want.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mck_pkg::CFG_WPM:  speed   = cfg_data[mck_pkg::WPM_W-1:0];
                    mck_pkg::CFG_TONE: tone_hz = cfg_data[mck_pkg::FREQ_W-1:0];
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
                key_character(character);
        end
        outstanding = pending_segments.size();
    end

endmodule

/* tb/tb.sv */
// Top of the Morse keyer testbench: clock, reset, stimulus and verdict.
// Depends on mck_pkg, morse_code_keyer_unit and keyer_check.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 16;
    localparam int NUM_PHASES   = 7;
    localparam int SETTLE_CYCLES = 20;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [mck_pkg::CHAR_W-1:0]     character;
    logic                           out_valid;
    logic                           out_ready;
    logic                           tone_on;
    logic [mck_pkg::FREQ_W-1:0]     frequency_out;
    logic [mck_pkg::UNITS_W-1:0]    unit_count;
    logic [mck_pkg::DUR_W-1:0]      duration_ms;
    logic                           last_segment;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mck_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mck_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             outstanding;
    int unsigned                    cycles;
    bit                             rush;

    // Coded characters drawn for well-formed text
    string coded_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789?.,/ ";
    string directed_text = "Az09?.,/ ETm5Z";
    logic [mck_pkg::CHAR_W-1:0] odd_chars [8] = '{
        8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1, 8'h2D
    };
    // Speed and tone per phase; -1 draws a random value
    int phase_speed [NUM_PHASES] = '{0, 40, 63, 10, 11, -1, 24};
    int phase_tone  [NUM_PHASES] = '{0, 8191, 1, 4095, -1, -1, 700};

    morse_code_keyer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tone_on       (tone_on),
        .frequency_out (frequency_out),
        .unit_count    (unit_count),
        .duration_ms   (duration_ms),
        .last_segment  (last_segment),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    keyer_check u_keyer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tone_on       (tone_on),
        .frequency_out (frequency_out),
        .unit_count    (unit_count),
        .duration_ms   (duration_ms),
        .last_segment  (last_segment),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: unless rushing, stall a random number of cycles before each transaction
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = rush ? 0 : int'($urandom_range(0, 13));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    // Hold the character until the block takes it
    task automatic send_character(input logic [mck_pkg::CHAR_W-1:0] c);
        int gap;
        gap = rush ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted segment has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write speed then tone in back-to-back transactions
    task automatic write_speed_and_tone(input logic [mck_pkg::WPM_W-1:0] wpm,
                                        input logic [mck_pkg::FREQ_W-1:0] hz);
        logic [mck_pkg::CFG_DATA_W-1:0] upper;
        upper     = mck_pkg::CFG_DATA_W'($urandom_range(0, 127));
        cfg_valid <= 1'b1;
        cfg_index <= mck_pkg::CFG_WPM;
        cfg_data  <= (upper << mck_pkg::WPM_W) | wpm;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= mck_pkg::CFG_TONE;
        cfg_data  <= hz;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [mck_pkg::WPM_W-1:0]  wpm;
        logic [mck_pkg::FREQ_W-1:0] hz;
        rst_n     = 1'b0;
        rush      = 1'b0;
        in_valid  = 1'b0;
        character = '0;
        cfg_valid = 1'b0;
        cfg_index = mck_pkg::CFG_WPM;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text and odd characters at the reset speed and tone
        for (int i = 0; i < directed_text.len(); i++)
            send_character(directed_text[i]);
        foreach (odd_chars[i])
            send_character(odd_chars[i]);
        settle();

        // Random text under a run of register settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wpm = (phase_speed[p] < 0) ? mck_pkg::WPM_W'($urandom_range(0, 63))
                                       : mck_pkg::WPM_W'(phase_speed[p]);
            hz  = (phase_tone[p] < 0) ? mck_pkg::FREQ_W'($urandom_range(0, 8191))
                                      : mck_pkg::FREQ_W'(phase_tone[p]);
            write_speed_and_tone(wpm, hz);
            rush = (p == 2 || p == 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_character(mck_pkg::CHAR_W'($urandom_range(0, 255)));
                else
                    send_character(coded_chars[$urandom_range(0, coded_chars.len() - 1)]);
            end
            settle();
            rush = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
